// File: rtl/rsed_pkg.sv
// rsed_pkg: shared constants, codes and types of the rgb sobel edge threshold block
// no dependencies; compile first
`timescale 1ns / 1ps

package rsed_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int LINE_AW   = $clog2(MAX_WIDTH);

  localparam int PIX_W    = 8;
  localparam int COL_W    = 10;
  localparam int ROW_W    = 12;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 12;
  localparam int THR_W    = 8;
  localparam int CFG_W    = 12;
  localparam int CFG_IW   = 2;
  localparam int PROD_W   = 24;
  localparam int SUM_W    = 10;
  localparam int MAG_W    = 11;

  localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IW-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_IW-1:0] REG_EDGE_THRESHOLD = 2'd2;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET     = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET    = 12'd480;
  localparam logic [THR_W-1:0]    THRESHOLD_RESET = 8'd100;
  localparam logic [WIDTH_W-1:0]  WIDTH_MIN       = 11'd3;
  localparam logic [WIDTH_W-1:0]  WIDTH_MAX       = WIDTH_W'(MAX_WIDTH);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN      = 12'd3;

  localparam logic [PROD_W-1:0] LUMA_R     = 24'd19595;
  localparam logic [PROD_W-1:0] LUMA_G     = 24'd38470;
  localparam logic [PROD_W-1:0] LUMA_B     = 24'd7471;
  localparam logic [PROD_W-1:0] LUMA_ROUND = 24'd32768;

  localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
  localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

  typedef struct packed {
    logic               emit;
    logic [COL_W-1:0]   x;
    logic [ROW_W-1:0]   y;
    logic [LINE_AW-1:0] addr;
  } pos_t;

  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] x;
    logic [ROW_W-1:0] y;
    logic [PIX_W-1:0] value;
  } result_t;

endpackage

// File: rtl/rsed_if.sv
// rsed_if: valid/ready stream interfaces for input pixels and edge results
// depends on rsed_pkg
`timescale 1ns / 1ps

interface rsed_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [rsed_pkg::PIX_W-1:0] red;
  logic [rsed_pkg::PIX_W-1:0] green;
  logic [rsed_pkg::PIX_W-1:0] blue;
  logic                      frame_start;

  modport source (output valid, red, green, blue, frame_start, input ready);
  modport sink (input valid, red, green, blue, frame_start, output ready);
endinterface

interface rsed_edge_if;
  logic                      valid;
  logic                      ready;
  logic [rsed_pkg::COL_W-1:0] pixel_x;
  logic [rsed_pkg::ROW_W-1:0] pixel_y;
  logic [rsed_pkg::PIX_W-1:0] edge_value;

  modport source (output valid, pixel_x, pixel_y, edge_value, input ready);
  modport sink (input valid, pixel_x, pixel_y, edge_value, output ready);
endinterface

// File: rtl/rsed_ram.sv
// rsed_ram: generic single-write, single-read ram with registered read
// read-first on a same-address write; no dependencies
`timescale 1ns / 1ps

module rsed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/rsed_pos.sv
// rsed_pos: configuration registers, frame position counters, line buffer address
// depends on rsed_pkg
`timescale 1ns / 1ps

module rsed_pos (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [rsed_pkg::CFG_IW-1:0] cfg_index,
  input  logic [rsed_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        accept,
  input  logic                        frame_start,
  output rsed_pkg::pos_t              pos,
  output logic [rsed_pkg::THR_W-1:0]  threshold
);

  logic [rsed_pkg::WIDTH_W-1:0]  image_width;
  logic [rsed_pkg::HEIGHT_W-1:0] image_height;
  logic [rsed_pkg::WIDTH_W-1:0]  width_eff;
  logic [rsed_pkg::HEIGHT_W-1:0] height_eff;
  logic [rsed_pkg::COL_W-1:0]    column_count;
  logic [rsed_pkg::ROW_W-1:0]    row_count;
  logic [rsed_pkg::COL_W-1:0]    col_cur;
  logic [rsed_pkg::ROW_W-1:0]    row_cur;
  logic [rsed_pkg::WIDTH_W-1:0]  col_inc;
  logic [rsed_pkg::ROW_W:0]      row_inc;
  logic [rsed_pkg::COL_W-1:0]    column_count_next;
  logic [rsed_pkg::ROW_W-1:0]    row_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= rsed_pkg::WIDTH_RESET;
      image_height <= rsed_pkg::HEIGHT_RESET;
      threshold    <= rsed_pkg::THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rsed_pkg::REG_IMAGE_WIDTH:    image_width  <= cfg_data[rsed_pkg::WIDTH_W-1:0];
        rsed_pkg::REG_IMAGE_HEIGHT:   image_height <= cfg_data[rsed_pkg::HEIGHT_W-1:0];
        rsed_pkg::REG_EDGE_THRESHOLD: threshold    <= cfg_data[rsed_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    width_eff = image_width;
    if (image_width < rsed_pkg::WIDTH_MIN) width_eff = rsed_pkg::WIDTH_MIN;
    if (image_width > rsed_pkg::WIDTH_MAX) width_eff = rsed_pkg::WIDTH_MAX;
    height_eff = (image_height < rsed_pkg::HEIGHT_MIN) ? rsed_pkg::HEIGHT_MIN : image_height;
  end

  always_comb begin
    col_cur = frame_start ? '0 : column_count;
    row_cur = frame_start ? '0 : row_count;
    col_inc = rsed_pkg::WIDTH_W'(col_cur) + 1'b1;
    row_inc = (rsed_pkg::ROW_W + 1)'(row_cur) + 1'b1;
    if (col_inc >= width_eff) begin
      column_count_next = '0;
      row_count_next    = (row_inc >= (rsed_pkg::ROW_W + 1)'(height_eff)) ? '0 :
                          row_inc[rsed_pkg::ROW_W-1:0];
    end else begin
      column_count_next = col_inc[rsed_pkg::COL_W-1:0];
      row_count_next    = row_cur;
    end
    pos.emit = (col_cur >= rsed_pkg::COL_W'(2)) && (row_cur >= rsed_pkg::ROW_W'(2)) &&
               (rsed_pkg::WIDTH_W'(col_cur) < width_eff) && (row_cur < height_eff);
    pos.x    = col_cur - 1'b1;
    pos.y    = row_cur - 1'b1;
    pos.addr = col_cur[rsed_pkg::LINE_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

// File: rtl/rsed_filter.sv
// rsed_filter: luma, line buffer read-modify-write with forwarding, 3x3 window, sobel
// depends on rsed_pkg and rsed_ram
`timescale 1ns / 1ps

module rsed_filter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic                       accept,
  input  rsed_pkg::pos_t             pos,
  input  logic [rsed_pkg::PIX_W-1:0] red,
  input  logic [rsed_pkg::PIX_W-1:0] green,
  input  logic [rsed_pkg::PIX_W-1:0] blue,
  input  logic [rsed_pkg::THR_W-1:0] threshold,
  output rsed_pkg::result_t          res
);

  logic                          v1;
  rsed_pkg::pos_t                pos1;
  logic [rsed_pkg::PROD_W-1:0]   prod_r;
  logic [rsed_pkg::PROD_W-1:0]   prod_g;
  logic [rsed_pkg::PROD_W-1:0]   prod_b;
  logic [rsed_pkg::PROD_W-1:0]   luma_sum;
  logic                          fwd_hit;
  logic [rsed_pkg::PIX_W-1:0]    fwd_top;
  logic [rsed_pkg::PIX_W-1:0]    fwd_mid;
  logic [rsed_pkg::PIX_W-1:0]    two_rdata;
  logic [rsed_pkg::PIX_W-1:0]    one_rdata;
  logic [rsed_pkg::PIX_W-1:0]    luma;
  logic [rsed_pkg::PIX_W-1:0]    top;
  logic [rsed_pkg::PIX_W-1:0]    mid;
  logic [rsed_pkg::PIX_W-1:0]    window_columns [6];
  logic [rsed_pkg::SUM_W-1:0]    right_sum;
  logic [rsed_pkg::SUM_W-1:0]    left_sum;
  logic [rsed_pkg::SUM_W-1:0]    upper_sum;
  logic [rsed_pkg::SUM_W-1:0]    lower_sum;
  logic                          v2;
  logic [rsed_pkg::COL_W-1:0]    x2;
  logic [rsed_pkg::ROW_W-1:0]    y2;
  logic [rsed_pkg::SUM_W-1:0]    right2;
  logic [rsed_pkg::SUM_W-1:0]    left2;
  logic [rsed_pkg::SUM_W-1:0]    upper2;
  logic [rsed_pkg::SUM_W-1:0]    lower2;
  logic [rsed_pkg::SUM_W-1:0]    gx;
  logic [rsed_pkg::SUM_W-1:0]    gy;
  logic [rsed_pkg::MAG_W-1:0]    mag;
  logic                          wr_en;

  assign wr_en = advance && v1;

  rsed_ram #(.WIDTH(rsed_pkg::PIX_W), .DEPTH(rsed_pkg::MAX_WIDTH)) u_line_two_back (
    .clk   (clk),
    .we    (wr_en),
    .waddr (pos1.addr),
    .wdata (mid),
    .re    (accept),
    .raddr (pos.addr),
    .rdata (two_rdata)
  );

  rsed_ram #(.WIDTH(rsed_pkg::PIX_W), .DEPTH(rsed_pkg::MAX_WIDTH)) u_line_one_back (
    .clk   (clk),
    .we    (wr_en),
    .waddr (pos1.addr),
    .wdata (luma),
    .re    (accept),
    .raddr (pos.addr),
    .rdata (one_rdata)
  );

  // stage 1: products, ram read, forwarding of the write in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pos1    <= pos;
      prod_r  <= rsed_pkg::LUMA_R * rsed_pkg::PROD_W'(red);
      prod_g  <= rsed_pkg::LUMA_G * rsed_pkg::PROD_W'(green);
      prod_b  <= rsed_pkg::LUMA_B * rsed_pkg::PROD_W'(blue);
      fwd_hit <= v1 && (pos1.addr == pos.addr);
      fwd_top <= mid;
      fwd_mid <= luma;
    end
  end

  always_comb begin
    luma_sum  = prod_r + prod_g + prod_b + rsed_pkg::LUMA_ROUND;
    luma      = luma_sum[rsed_pkg::PROD_W-1:rsed_pkg::PROD_W-rsed_pkg::PIX_W];
    top       = fwd_hit ? fwd_top : two_rdata;
    mid       = fwd_hit ? fwd_mid : one_rdata;
    right_sum = {2'b00, top} + {1'b0, mid, 1'b0} + {2'b00, luma};
    left_sum  = {2'b00, window_columns[0]} + {1'b0, window_columns[1], 1'b0} +
                {2'b00, window_columns[2]};
    upper_sum = {2'b00, window_columns[0]} + {1'b0, window_columns[3], 1'b0} +
                {2'b00, top};
    lower_sum = {2'b00, window_columns[2]} + {1'b0, window_columns[5], 1'b0} +
                {2'b00, luma};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        window_columns[i] <= '0;
      end
    end else if (wr_en) begin
      window_columns[0] <= window_columns[3];
      window_columns[1] <= window_columns[4];
      window_columns[2] <= window_columns[5];
      window_columns[3] <= top;
      window_columns[4] <= mid;
      window_columns[5] <= luma;
    end
  end

  // stage 2: magnitude and threshold
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance) begin
      v2 <= v1 && pos1.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      x2     <= pos1.x;
      y2     <= pos1.y;
      right2 <= right_sum;
      left2  <= left_sum;
      upper2 <= upper_sum;
      lower2 <= lower_sum;
    end
  end

  always_comb begin
    gx        = (right2 >= left2) ? right2 - left2 : left2 - right2;
    gy        = (upper2 >= lower2) ? upper2 - lower2 : lower2 - upper2;
    mag       = {1'b0, gx} + {1'b0, gy};
    res.valid = v2;
    res.x     = x2;
    res.y     = y2;
    res.value = (mag[rsed_pkg::MAG_W-1:3] >= threshold) ? rsed_pkg::EDGE_ON :
                rsed_pkg::EDGE_OFF;
  end

endmodule

// File: rtl/rgb_sobel_edge_threshold_top.sv
// rgb_sobel_edge_threshold_top: rgb pixel stream in, thresholded sobel edges out
// depends on rsed_pkg, rsed_if, rsed_pos, rsed_filter, rsed_ram
// a result reaches the output through the stage 1, stage 2 and output registers after its pixel transfer
// throughput: one pixel per cycle, set by the single read and write port of each line buffer;
// input stalls only while a result sits in the last stage and the output is held
// reset: counters, window and registers (640, 480, 100) clear at once; line buffers are not
// cleared and need no clearing pass
`timescale 1ns / 1ps

module rgb_sobel_edge_threshold_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [rsed_pkg::CFG_IW-1:0] cfg_index,
  input  logic [rsed_pkg::CFG_W-1:0]  cfg_data,
  rsed_pixel_if.sink                  pixels,
  rsed_edge_if.source                 edges
);

  rsed_pkg::pos_t               pos;
  rsed_pkg::result_t            res;
  logic [rsed_pkg::THR_W-1:0]   threshold;
  logic                         advance;
  logic                         accept;
  logic                         out_valid;
  logic [rsed_pkg::COL_W-1:0]   out_x;
  logic [rsed_pkg::ROW_W-1:0]   out_y;
  logic [rsed_pkg::PIX_W-1:0]   out_value;

  assign advance      = !(out_valid && !edges.ready && res.valid);
  assign accept       = pixels.valid && advance;
  assign pixels.ready = advance;

  rsed_pos u_pos (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .frame_start (pixels.frame_start),
    .pos         (pos),
    .threshold   (threshold)
  );

  rsed_filter u_filter (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .accept    (accept),
    .pos       (pos),
    .red       (pixels.red),
    .green     (pixels.green),
    .blue      (pixels.blue),
    .threshold (threshold),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid <= 1'b1;
    end else if (edges.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_x     <= res.x;
      out_y     <= res.y;
      out_value <= res.value;
    end
  end

  assign edges.valid      = out_valid;
  assign edges.pixel_x    = out_x;
  assign edges.pixel_y    = out_y;
  assign edges.edge_value = out_value;

  a_stall_needs_full_output: assert property (@(posedge clk) disable iff (rst)
    !advance |-> (out_valid && res.valid))
    else $error("pipeline stalled without a pending result");

  a_edge_value_code: assert property (@(posedge clk) disable iff (rst)
    edges.valid |-> (edges.edge_value == rsed_pkg::EDGE_ON ||
                     edges.edge_value == rsed_pkg::EDGE_OFF))
    else $error("edge value is neither on nor off");

  a_interior_only: assert property (@(posedge clk) disable iff (rst)
    edges.valid |-> (edges.pixel_x != '0 && edges.pixel_y != '0))
    else $error("border pixel emitted");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (advance && res.valid) |=> out_valid)
    else $error("result lost at output register");

endmodule

// File: bench/rgb_sobel_edge_threshold_top_tb.sv
// rgb_sobel_edge_threshold_top_tb: self-checking bench for the rgb sobel edge threshold block,
// a directed pixel table then random frames over many sizes, checked against a luma/sobel predictor
// depends on rsed_pkg, rsed_if and rgb_sobel_edge_threshold_top
`timescale 1ns / 1ps

module rgb_sobel_edge_threshold_top_tb;

  localparam int CYCLE_LIMIT   = 60000;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_ITEMS  = 1000;
  localparam logic [rsed_pkg::CFG_IW-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [rsed_pkg::COL_W-1:0] x;
    logic [rsed_pkg::ROW_W-1:0] y;
    logic [rsed_pkg::PIX_W-1:0] value;
  } edge_rec_t;

  typedef struct packed {
    logic [rsed_pkg::PIX_W-1:0] red;
    logic [rsed_pkg::PIX_W-1:0] green;
    logic [rsed_pkg::PIX_W-1:0] blue;
    logic                       fs;
    logic                       typed;
    logic                       emit;
    edge_rec_t                  rec;
  } stim_row_t;

  logic                        clk;
  logic                        rst;
  logic                        cfg_we;
  logic [rsed_pkg::CFG_IW-1:0] cfg_index;
  logic [rsed_pkg::CFG_W-1:0]  cfg_data;

  rsed_pixel_if pixel_bus ();
  rsed_edge_if  edge_bus ();

  rgb_sobel_edge_threshold_top DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pixels   (pixel_bus),
    .edges    (edge_bus)
  );

  // predictor state
  logic [rsed_pkg::PIX_W-1:0]    luma_two_up [rsed_pkg::MAX_WIDTH];
  logic [rsed_pkg::PIX_W-1:0]    luma_one_up [rsed_pkg::MAX_WIDTH];
  logic [rsed_pkg::PIX_W-1:0]    window_luma [6];
  int                            col_pos;
  int                            row_pos;
  logic [rsed_pkg::WIDTH_W-1:0]  cfg_width;
  logic [rsed_pkg::HEIGHT_W-1:0] cfg_height;
  logic [rsed_pkg::THR_W-1:0]    cfg_thresh;

  edge_rec_t pending_edges[$];
  stim_row_t directed_rows[$];
  int        errors;
  int        cycle_count;
  int        random_sent;
  bit        src_idle_on;
  bit        sink_idle_on;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [rsed_pkg::PIX_W-1:0] luma_of_rgb(
      input logic [rsed_pkg::PIX_W-1:0] r,
      input logic [rsed_pkg::PIX_W-1:0] g,
      input logic [rsed_pkg::PIX_W-1:0] b);
    logic [rsed_pkg::PROD_W-1:0] acc;
    acc = rsed_pkg::LUMA_R * rsed_pkg::PROD_W'(r) + rsed_pkg::LUMA_G * rsed_pkg::PROD_W'(g) +
          rsed_pkg::LUMA_B * rsed_pkg::PROD_W'(b) + rsed_pkg::LUMA_ROUND;
    return acc[rsed_pkg::PROD_W-1:rsed_pkg::PROD_W-rsed_pkg::PIX_W];
  endfunction

  task automatic predict_edge(input stim_row_t row, output bit emit, output edge_rec_t rec);
    int eff_w, eff_h, idx, top, mid, lum;
    int right_sum, left_sum, upper_sum, lower_sum, gx, gy, mag;
    eff_w = int'(cfg_width);
    eff_h = int'(cfg_height);
    if (eff_w < 3) eff_w = 3;
    if (eff_w > rsed_pkg::MAX_WIDTH) eff_w = rsed_pkg::MAX_WIDTH;
    if (eff_h < 3) eff_h = 3;
    if (row.fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    lum = int'(luma_of_rgb(row.red, row.green, row.blue));
    idx = (col_pos < rsed_pkg::MAX_WIDTH) ? col_pos : rsed_pkg::MAX_WIDTH - 1;
    top = int'(luma_two_up[idx]);
    mid = int'(luma_one_up[idx]);
    luma_two_up[idx] = mid[rsed_pkg::PIX_W-1:0];
    luma_one_up[idx] = lum[rsed_pkg::PIX_W-1:0];
    emit = 1'b0;
    rec = '0;
    if (col_pos >= 2 && row_pos >= 2 && col_pos < eff_w && row_pos < eff_h) begin
      right_sum = top + 2 * mid + lum;
      left_sum  = int'(window_luma[0]) + 2 * int'(window_luma[1]) + int'(window_luma[2]);
      upper_sum = int'(window_luma[0]) + 2 * int'(window_luma[3]) + top;
      lower_sum = int'(window_luma[2]) + 2 * int'(window_luma[5]) + lum;
      gx = right_sum - left_sum;
      gy = upper_sum - lower_sum;
      if (gx < 0) gx = -gx;
      if (gy < 0) gy = -gy;
      mag = (gx + gy) >> 3;
      emit = 1'b1;
      rec.x = rsed_pkg::COL_W'(col_pos - 1);
      rec.y = rsed_pkg::ROW_W'(row_pos - 1);
      rec.value = (mag >= int'(cfg_thresh)) ? rsed_pkg::EDGE_ON : rsed_pkg::EDGE_OFF;
    end
    window_luma[0] = window_luma[3];
    window_luma[1] = window_luma[4];
    window_luma[2] = window_luma[5];
    window_luma[3] = top[rsed_pkg::PIX_W-1:0];
    window_luma[4] = mid[rsed_pkg::PIX_W-1:0];
    window_luma[5] = lum[rsed_pkg::PIX_W-1:0];
    if (col_pos + 1 >= eff_w) begin
      col_pos = 0;
      if (row_pos + 1 >= eff_h) row_pos = 0;
      else row_pos = row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  // one pixel transfer, expectation queued at the accepting edge
  task automatic send_pixel(input stim_row_t row);
    bit        emit;
    edge_rec_t rec;
    @(negedge clk);
    while (src_idle_on && $urandom_range(0, 99) < 11) begin
      pixel_bus.valid = 1'b0;
      @(negedge clk);
    end
    pixel_bus.valid       = 1'b1;
    pixel_bus.red         = row.red;
    pixel_bus.green       = row.green;
    pixel_bus.blue        = row.blue;
    pixel_bus.frame_start = row.fs;
    do @(posedge clk); while (pixel_bus.ready !== 1'b1);
    predict_edge(row, emit, rec);
    if (row.typed) begin
      if (row.emit) pending_edges.push_back(row.rec);
    end else if (emit) begin
      pending_edges.push_back(rec);
    end
  endtask

  task automatic settle_block();
    @(negedge clk);
    pixel_bus.valid = 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rsed_pkg::CFG_IW-1:0] idx,
                           input logic [rsed_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      rsed_pkg::REG_IMAGE_WIDTH:    cfg_width  = data[rsed_pkg::WIDTH_W-1:0];
      rsed_pkg::REG_IMAGE_HEIGHT:   cfg_height = data[rsed_pkg::HEIGHT_W-1:0];
      rsed_pkg::REG_EDGE_THRESHOLD: cfg_thresh = data[rsed_pkg::THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic add_row(input logic [rsed_pkg::PIX_W-1:0] r,
                         input logic [rsed_pkg::PIX_W-1:0] g,
                         input logic [rsed_pkg::PIX_W-1:0] b, input logic fs, input logic typed,
                         input logic emit, input logic [rsed_pkg::COL_W-1:0] x,
                         input logic [rsed_pkg::ROW_W-1:0] y,
                         input logic [rsed_pkg::PIX_W-1:0] v);
    stim_row_t row;
    row.red = r;
    row.green = g;
    row.blue = b;
    row.fs = fs;
    row.typed = typed;
    row.emit = emit;
    row.rec.x = x;
    row.rec.y = y;
    row.rec.value = v;
    directed_rows.push_back(row);
  endtask

  // waits for pending results, writes the size and threshold, then streams npix pixels of mixed content
  task automatic run_phase(input logic [rsed_pkg::CFG_W-1:0] w_data,
                           input logic [rsed_pkg::CFG_W-1:0] h_data,
                           input logic [rsed_pkg::CFG_W-1:0] thr_data, input int npix,
                           input bit restart, input bit noise);
    stim_row_t row;
    logic [rsed_pkg::PIX_W-1:0] pr, pg, pb;
    int mode;
    settle_block();
    write_reg(rsed_pkg::REG_IMAGE_WIDTH, w_data);
    write_reg(rsed_pkg::REG_IMAGE_HEIGHT, h_data);
    write_reg(rsed_pkg::REG_EDGE_THRESHOLD, thr_data);
    pr = '0;
    pg = '0;
    pb = '0;
    for (int i = 0; i < npix; i++) begin
      mode = $urandom_range(0, 9);
      if (mode >= 6) begin
        pr = rsed_pkg::PIX_W'($urandom_range(0, 255));
        pg = rsed_pkg::PIX_W'($urandom_range(0, 255));
        pb = rsed_pkg::PIX_W'($urandom_range(0, 255));
      end else if (mode >= 4) begin
        pr = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        pg = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        pb = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      end
      row = '0;
      row.red = pr;
      row.green = pg;
      row.blue = pb;
      row.fs = (i == 0) ? restart : (noise && $urandom_range(0, 79) == 0);
      send_pixel(row);
    end
  endtask

  // result checking
  always @(posedge clk) begin
    edge_rec_t want;
    if (!rst && edge_bus.valid === 1'b1 && edge_bus.ready === 1'b1) begin
      if (pending_edges.size() == 0) begin
        errors++;
        $display("%0t: unexpected result x=%0d y=%0d value=%0d", $time,
                 edge_bus.pixel_x, edge_bus.pixel_y, edge_bus.edge_value);
      end else begin
        want = pending_edges.pop_front();
        if (edge_bus.pixel_x !== want.x || edge_bus.pixel_y !== want.y ||
            edge_bus.edge_value !== want.value) begin
          errors++;
          $display("%0t: mismatch expected x=%0d y=%0d value=%0d, actual x=%0d y=%0d value=%0d",
                   $time, want.x, want.y, want.value,
                   edge_bus.pixel_x, edge_bus.pixel_y, edge_bus.edge_value);
        end
      end
    end
  end

  always @(negedge clk) begin
    edge_bus.ready = !(sink_idle_on && $urandom_range(0, 99) < 11);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int w, h, thr, ew, eh, npix;
    logic [rsed_pkg::CFG_W-1:0] wd, td;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = rsed_pkg::REG_IMAGE_WIDTH;
    cfg_data = '0;
    pixel_bus.valid = 1'b0;
    pixel_bus.red = '0;
    pixel_bus.green = '0;
    pixel_bus.blue = '0;
    pixel_bus.frame_start = 1'b0;
    edge_bus.ready = 1'b0;
    errors = 0;
    random_sent = 0;
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    col_pos = 0;
    row_pos = 0;
    cfg_width = rsed_pkg::WIDTH_RESET;
    cfg_height = rsed_pkg::HEIGHT_RESET;
    cfg_thresh = rsed_pkg::THRESHOLD_RESET;
    for (int i = 0; i < rsed_pkg::MAX_WIDTH; i++) begin
      luma_two_up[i] = '0;
      luma_one_up[i] = '0;
    end
    for (int i = 0; i < 6; i++) window_luma[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // 3x3 frames, width and height below range, threshold at reset
    write_reg(rsed_pkg::REG_IMAGE_WIDTH, 12'd0);
    write_reg(rsed_pkg::REG_IMAGE_HEIGHT, 12'd1);
    // black, gray, white columns: vertical edge
    for (int r = 0; r < 3; r++) begin
      add_row(8'd0, 8'd0, 8'd0, r == 0, 1'b1, 1'b0, '0, '0, '0);
      add_row(8'd128, 8'd128, 8'd128, 1'b0, 1'b1, 1'b0, '0, '0, '0);
      add_row(8'd255, 8'd255, 8'd255, 1'b0, 1'b1, r == 2, 10'd1, 12'd1, rsed_pkg::EDGE_ON);
    end
    // flat white frame after the row wrap, no frame start
    for (int i = 0; i < 9; i++)
      add_row(8'd255, 8'd255, 8'd255, 1'b0, 1'b1, i == 8, 10'd1, 12'd1, rsed_pkg::EDGE_OFF);
    // single and dual channel extremes, near-black and near-white pixels, predicted
    add_row(8'd255, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0, '0, '0, '0);
    add_row(8'd0, 8'd255, 8'd0, 1'b0, 1'b0, 1'b0, '0, '0, '0);
    add_row(8'd0, 8'd0, 8'd255, 1'b0, 1'b0, 1'b0, '0, '0, '0);
    add_row(8'd255, 8'd255, 8'd0, 1'b0, 1'b0, 1'b0, '0, '0, '0);
    add_row(8'd0, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0, '0, '0, '0);
    add_row(8'd255, 8'd0, 8'd255, 1'b0, 1'b0, 1'b0, '0, '0, '0);
    add_row(8'd1, 8'd2, 8'd4, 1'b0, 1'b0, 1'b0, '0, '0, '0);
    add_row(8'd254, 8'd253, 8'd251, 1'b0, 1'b0, 1'b0, '0, '0, '0);
    add_row(8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, '0, '0, '0);
    foreach (directed_rows[i]) send_pixel(directed_rows[i]);

    // write to the unused register index; the next phase writes every register anew
    settle_block();
    write_reg(REG_SPARE, rsed_pkg::CFG_W'($urandom));

    // threshold extremes on small frames
    run_phase(12'd3, 12'd3, 12'd0, 20, 1'b1, 1'b0);
    run_phase(12'd4, 12'd3, 12'hFFF, 26, 1'b1, 1'b0);

    // width above range clamps to the maximum, start of a wide line
    run_phase(12'hFFF, 12'd3, 12'd24, 20, 1'b1, 1'b0);

    // long narrow frame at full rate, no idling on either side
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    run_phase(12'd3, 12'd100, 12'd30, 3 * 100 + 6, 1'b1, 1'b0);
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;

    // shrink width and height mid frame, position lands beyond both
    run_phase(12'd16, 12'd10, 12'd40, 7 * 16 + 10, 1'b1, 1'b0);
    run_phase(12'd6, 12'd5, 12'd40, 60, 1'b0, 1'b0);

    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       w = $urandom_range(0, 2);
        1, 2:    w = $urandom_range(13, 48);
        default: w = $urandom_range(3, 12);
      endcase
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
      case ($urandom_range(0, 3))
        0:       thr = $urandom_range(0, 255);
        1:       thr = $urandom_range(0, 30);
        default: thr = $urandom_range(15, 90);
      endcase
      ew = (w < 3) ? 3 : w;
      eh = (h < 3) ? 3 : h;
      npix = ew * eh * $urandom_range(1, 2) + $urandom_range(0, ew);
      wd = rsed_pkg::CFG_W'(w);
      wd[rsed_pkg::CFG_W-1] = 1'($urandom_range(0, 1));
      td = rsed_pkg::CFG_W'(thr);
      td[rsed_pkg::CFG_W-1:rsed_pkg::THR_W] =
        (rsed_pkg::CFG_W - rsed_pkg::THR_W)'($urandom_range(0, 15));
      run_phase(wd, rsed_pkg::CFG_W'(h), td, npix, 1'b1, 1'b1);
      random_sent += npix;
    end

    settle_block();
    repeat (8) @(posedge clk);
    if (pending_edges.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, pending_edges.size());
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
